FILE: rtl/cabs_pkg.sv
// Shared constants, request types and status codes for the class-aware box suppression block.
`default_nettype none

package cabs_pkg;

  // Kept table geometry
  localparam int MAX_KEPT = 64;
  localparam int KEPT_AW  = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int KCNT_W   = $clog2(MAX_KEPT + 1);

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_CONF_THR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OVL_THR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLASS_CNT = 2'd2;

  localparam logic [15:0] CONF_THR_RST  = 16'd16384;
  localparam logic [15:0] OVL_THR_RST   = 16'd29491;
  localparam logic [7:0]  CLASS_CNT_RST = 8'd80;

  // Result status codes
  localparam logic [2:0] ST_KEPT       = 3'd0;
  localparam logic [2:0] ST_SUPPRESSED = 3'd1;
  localparam logic [2:0] ST_LOW_SCORE  = 3'd2;
  localparam logic [2:0] ST_DEGENERATE = 3'd3;
  localparam logic [2:0] ST_BAD_CLASS  = 3'd4;
  localparam logic [2:0] ST_TABLE_FULL = 3'd5;

  typedef struct packed {
    logic        first_of_image;
    logic [7:0]  class_index;
    logic [15:0] score;
    logic [15:0] box_left;
    logic [15:0] box_top;
    logic [15:0] box_right;
    logic [15:0] box_bottom;
  } in_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  out_class;
    logic [15:0] out_score;
    logic [15:0] out_left;
    logic [15:0] out_top;
    logic [15:0] out_width;
    logic [15:0] out_height;
  } out_req_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;  // take the input request
    logic issue;   // read one table entry into the overlap pipe
    logic finish;  // load the result and update the table
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic quick;       // screened out before any overlap test
    logic empty;       // no kept entries
    logic issue_last;  // current read address is the last kept entry
    logic pipe_busy;   // overlap pipe still holds entries
    logic out_busy;    // result register full and stalled
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/cabs_ctrl.sv
// Sequencer for one request: screen, table scan, drain, result hand-off.
`default_nettype none

module cabs_ctrl import cabs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (stat.quick || stat.empty) state_nxt = S_FINISH;
        else state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (stat.issue_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (!stat.pipe_busy) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!stat.out_busy) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall   = (state_r != S_IDLE);
  assign cmd.accept = in_valid && (state_r == S_IDLE);
  assign cmd.issue  = (state_r == S_SCAN);
  assign cmd.finish = (state_r == S_FINISH) && !stat.out_busy;

  // a new request never lands while the previous one is still being worked
  a_accept_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> !cmd.issue && !cmd.finish && !stat.pipe_busy)
    else $error("request accepted while scan or hand-off in progress");

  // the pipe is drained before the result is taken
  a_finish_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !stat.pipe_busy)
    else $error("result loaded with overlap pipe not empty");

endmodule

`default_nettype wire

FILE: rtl/cabs_dp.sv
// Datapath: config registers, kept-box table, overlap pipe and result register.
`default_nettype none

module cabs_dp import cabs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  in_req_t               in_req,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  input  logic                  out_stall,
  output logic                  out_valid,
  output out_req_t              out_req
);

  localparam int PIPE_D = 5;
  localparam int PROD_W = 49;

  typedef struct packed {
    logic [7:0]  cls;
    logic [15:0] bottom;
    logic [15:0] right;
    logic [15:0] top;
    logic [15:0] left;
  } kept_entry_t;

  function automatic logic [15:0] span(input logic [15:0] lo, input logic [15:0] hi);
    span = (hi > lo) ? (hi - lo) : 16'd0;
  endfunction

  // configuration
  logic [15:0] conf_thr_r;
  logic [15:0] ovl_thr_r;
  logic [7:0]  class_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conf_thr_r  <= CONF_THR_RST;
      ovl_thr_r   <= OVL_THR_RST;
      class_cnt_r <= CLASS_CNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CONF_THR:  conf_thr_r  <= cfg_data;
        REG_OVL_THR:   ovl_thr_r   <= cfg_data;
        REG_CLASS_CNT: class_cnt_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // current request
  in_req_t     item_r;
  logic [15:0] box_w;
  logic [15:0] box_h;
  logic [31:0] area_a_r;

  assign box_w = span(item_r.box_left, item_r.box_right);
  assign box_h = span(item_r.box_top, item_r.box_bottom);

  always_ff @(posedge clk) begin
    if (cmd.accept) item_r <= in_req;
    area_a_r <= 32'(box_w) * 32'(box_h);
  end

  // screening and final status
  logic        low_score;
  logic        bad_class;
  logic        degenerate;
  logic        table_full;
  logic        hit_r;
  logic [2:0]  status_nxt;
  logic [KCNT_W-1:0]  count_r;
  logic [KEPT_AW-1:0] rd_addr_r;
  logic [PIPE_D-1:0]  vld_r;

  assign low_score  = item_r.score < conf_thr_r;
  assign bad_class  = item_r.class_index >= class_cnt_r;
  assign degenerate = (item_r.box_right <= item_r.box_left) ||
                      (item_r.box_bottom <= item_r.box_top);
  assign table_full = count_r >= KCNT_W'(MAX_KEPT);

  always_comb begin
    if (low_score)       status_nxt = ST_LOW_SCORE;
    else if (bad_class)  status_nxt = ST_BAD_CLASS;
    else if (degenerate) status_nxt = ST_DEGENERATE;
    else if (hit_r)      status_nxt = ST_SUPPRESSED;
    else if (table_full) status_nxt = ST_TABLE_FULL;
    else                 status_nxt = ST_KEPT;
  end

  // kept table
  kept_entry_t kept_mem [MAX_KEPT];
  kept_entry_t rd_data_r;
  kept_entry_t wr_entry;

  assign wr_entry = '{cls: item_r.class_index, bottom: item_r.box_bottom,
                      right: item_r.box_right, top: item_r.box_top,
                      left: item_r.box_left};

  always_ff @(posedge clk) begin
    if (cmd.finish && (status_nxt == ST_KEPT)) begin
      kept_mem[count_r[KEPT_AW-1:0]] <= wr_entry;
    end
    if (cmd.issue) rd_data_r <= kept_mem[rd_addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      rd_addr_r <= '0;
      vld_r     <= '0;
    end else begin
      if (cmd.accept && in_req.first_of_image) count_r <= '0;
      else if (cmd.finish && (status_nxt == ST_KEPT)) count_r <= count_r + KCNT_W'(1);
      if (cmd.accept) rd_addr_r <= '0;
      else if (cmd.issue) rd_addr_r <= rd_addr_r + KEPT_AW'(1);
      vld_r <= {vld_r[PIPE_D-2:0], cmd.issue};
    end
  end

  // overlap pipe, one kept entry per cycle
  logic        cm1_r, cm2_r, cm3_r, cm4_r;
  logic [15:0] iw1_r, ih1_r, kw1_r, kh1_r;
  logic [31:0] inter2_r, area_b2_r, inter3_r, inter4_r;
  logic [32:0] uni3_r;
  logic [PROD_W-1:0] prod4_r;
  logic [15:0] il, it, ir, ib;

  assign il = (item_r.box_left > rd_data_r.left)     ? item_r.box_left   : rd_data_r.left;
  assign it = (item_r.box_top > rd_data_r.top)       ? item_r.box_top    : rd_data_r.top;
  assign ir = (item_r.box_right < rd_data_r.right)   ? item_r.box_right  : rd_data_r.right;
  assign ib = (item_r.box_bottom < rd_data_r.bottom) ? item_r.box_bottom : rd_data_r.bottom;

  always_ff @(posedge clk) begin
    cm1_r <= (rd_data_r.cls == item_r.class_index);
    iw1_r <= span(il, ir);
    ih1_r <= span(it, ib);
    kw1_r <= span(rd_data_r.left, rd_data_r.right);
    kh1_r <= span(rd_data_r.top, rd_data_r.bottom);

    cm2_r     <= cm1_r;
    inter2_r  <= 32'(iw1_r) * 32'(ih1_r);
    area_b2_r <= 32'(kw1_r) * 32'(kh1_r);

    cm3_r    <= cm2_r;
    inter3_r <= inter2_r;
    uni3_r   <= {1'b0, area_a_r} + {1'b0, area_b2_r} - {1'b0, inter2_r};

    cm4_r    <= cm3_r;
    inter4_r <= inter3_r;
    prod4_r  <= PROD_W'(ovl_thr_r) * PROD_W'(uni3_r);
  end

  // IoU > thr/65536  <=>  inter * 65536 > thr * union
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (cmd.accept) begin
      hit_r <= 1'b0;
    end else if (vld_r[PIPE_D-1] && cm4_r && ({1'b0, inter4_r, 16'h0000} > prod4_r)) begin
      hit_r <= 1'b1;
    end
  end

  // result register
  logic     out_valid_r;
  out_req_t out_req_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_req_r.status     <= status_nxt;
      out_req_r.out_class  <= item_r.class_index;
      out_req_r.out_score  <= item_r.score;
      out_req_r.out_left   <= item_r.box_left;
      out_req_r.out_top    <= item_r.box_top;
      out_req_r.out_width  <= box_w;
      out_req_r.out_height <= box_h;
    end
  end

  assign out_valid = out_valid_r;
  assign out_req   = out_req_r;

  assign stat.quick      = low_score || bad_class || degenerate;
  assign stat.empty      = (count_r == '0);
  assign stat.issue_last = (KCNT_W'(rd_addr_r) + KCNT_W'(1)) == count_r;
  assign stat.pipe_busy  = |vld_r;
  assign stat.out_busy   = out_valid_r && out_stall;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= KCNT_W'(MAX_KEPT))
    else $error("kept count beyond table depth");

  a_issue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> (KCNT_W'(rd_addr_r) < count_r))
    else $error("table read beyond kept entries");

  a_keep_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish && (status_nxt == ST_KEPT) |=> count_r == $past(count_r) + KCNT_W'(1))
    else $error("kept box not counted");

  a_full_only_at_depth: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish && (status_nxt == ST_TABLE_FULL) |-> count_r == KCNT_W'(MAX_KEPT))
    else $error("table-full status with room left");

endmodule

`default_nettype wire

FILE: rtl/class_aware_box_suppression.sv
// Top level of the class-aware greedy box suppression block.
`default_nettype none

// Boxes arrive one request at a time, already sorted by falling score and in
// image corner coordinates. Each gets one status: low score, bad class,
// degenerate, suppressed (IoU above threshold against a kept box of the same
// class), kept, or table full. Kept boxes live in a MAX_KEPT-entry table that
// a request with first_of_image set empties before it is judged.
// A request screened out on score, class or geometry, or met with an
// empty table, goes from the check state straight to the hand-off. A box
// tested against kept entries is scanned first: the table has one read
// port, so one entry enters the five-stage overlap pipe per cycle, and the
// pipe drains before the status is known. One request is worked at a time;
// the result sits in an output register, so the next request is taken while
// an earlier result is stalled. There is no clearing pass after reset; the
// table is never read past the kept count. Configuration writes are to be
// made only while the block is idle; the block itself does not enforce it.

module class_aware_box_suppression import cabs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_req_t               in_req,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_req_t              out_req
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: screen, scan the table, drain the pipe, hand off
  cabs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // registers, kept table, overlap arithmetic and result register
  cabs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_req    (in_req),
    .cmd       (cmd),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_req   (out_req)
  );

endmodule

`default_nettype wire

FILE: tb/sv/suppression_checker.sv
// Checker for the box suppression block: tracks registers, predicts each status and compares.

module suppression_checker import cabs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_req_t               in_req,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_req_t              out_req,
  output int unsigned           mismatches,
  output int unsigned           backlog
);

  logic [15:0] conf_floor = CONF_THR_RST;
  logic [15:0] iou_limit  = OVL_THR_RST;
  logic [7:0]  class_limit = CLASS_CNT_RST;

  // Own copy of the kept table
  logic [7:0]  kept_cls [MAX_KEPT];
  in_req_t     kept_box [MAX_KEPT];
  int unsigned kept_n = 0;

  out_req_t    verdicts [$];
  out_req_t    want;
  int unsigned bad_count = 0;
  int unsigned queued = 0;

  assign mismatches = bad_count;
  assign backlog    = queued;

  function automatic logic [15:0] extent(logic [15:0] lo, logic [15:0] hi);
    return (hi > lo) ? hi - lo : 16'd0;
  endfunction

  // IoU above the limit, tested as inter * 2^16 > limit * union
  function automatic bit overlap_hit(in_req_t a, in_req_t k);
    logic [15:0] il, it, ir, ib;
    logic [63:0] inter, area_a, area_k, uni;
    il = (a.box_left > k.box_left) ? a.box_left : k.box_left;
    it = (a.box_top > k.box_top) ? a.box_top : k.box_top;
    ir = (a.box_right < k.box_right) ? a.box_right : k.box_right;
    ib = (a.box_bottom < k.box_bottom) ? a.box_bottom : k.box_bottom;
    inter  = 64'(extent(il, ir)) * 64'(extent(it, ib));
    area_a = 64'(extent(a.box_left, a.box_right)) * 64'(extent(a.box_top, a.box_bottom));
    area_k = 64'(extent(k.box_left, k.box_right)) * 64'(extent(k.box_top, k.box_bottom));
    uni    = area_a + area_k - inter;
    if (uni == 64'd0) return 1'b0;
    return (inter << 16) > (64'(iou_limit) * uni);
  endfunction

  function automatic out_req_t judge_box(in_req_t q);
    out_req_t v;
    bit hit;
    int unsigned k;
    hit = 1'b0;
    k = 0;
    if (q.first_of_image) kept_n = 0;
    if (q.score < conf_floor) begin
      v.status = ST_LOW_SCORE;
    end else if (q.class_index >= class_limit) begin
      v.status = ST_BAD_CLASS;
    end else if (q.box_right <= q.box_left || q.box_bottom <= q.box_top) begin
      v.status = ST_DEGENERATE;
    end else begin
      while (k < kept_n && !hit) begin
        if (kept_cls[k] == q.class_index && overlap_hit(q, kept_box[k])) hit = 1'b1;
        k++;
      end
      if (hit) begin
        v.status = ST_SUPPRESSED;
      end else if (kept_n >= MAX_KEPT) begin
        v.status = ST_TABLE_FULL;
      end else begin
        kept_cls[kept_n] = q.class_index;
        kept_box[kept_n] = q;
        kept_n++;
        v.status = ST_KEPT;
      end
    end
    v.out_class  = q.class_index;
    v.out_score  = q.score;
    v.out_left   = q.box_left;
    v.out_top    = q.box_top;
    v.out_width  = extent(q.box_left, q.box_right);
    v.out_height = extent(q.box_top, q.box_bottom);
    return v;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      conf_floor  = CONF_THR_RST;
      iou_limit   = OVL_THR_RST;
      class_limit = CLASS_CNT_RST;
      kept_n = 0;
      verdicts.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CONF_THR:  conf_floor  = cfg_data[15:0];
          REG_OVL_THR:   iou_limit   = cfg_data[15:0];
          REG_CLASS_CNT: class_limit = cfg_data[7:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (verdicts.size() == 0) begin
          bad_count++;
          if (bad_count <= 10)
            $display("unexpected result: st=%0d cls=%0d sc=%0d l=%0d t=%0d w=%0d h=%0d",
                     out_req.status, out_req.out_class, out_req.out_score, out_req.out_left,
                     out_req.out_top, out_req.out_width, out_req.out_height);
        end else begin
          want = verdicts.pop_front();
          if (out_req.status !== want.status || out_req.out_class !== want.out_class ||
              out_req.out_score !== want.out_score || out_req.out_left !== want.out_left ||
              out_req.out_top !== want.out_top || out_req.out_width !== want.out_width ||
              out_req.out_height !== want.out_height) begin
            bad_count++;
            if (bad_count <= 10) begin
              $display("mismatch: want st=%0d cls=%0d sc=%0d l=%0d t=%0d w=%0d h=%0d",
                       want.status, want.out_class, want.out_score, want.out_left,
                       want.out_top, want.out_width, want.out_height);
              $display("          got  st=%0d cls=%0d sc=%0d l=%0d t=%0d w=%0d h=%0d",
                       out_req.status, out_req.out_class, out_req.out_score,
                       out_req.out_left, out_req.out_top, out_req.out_width,
                       out_req.out_height);
            end
          end
        end
      end
      if (in_valid && !in_stall) verdicts = {verdicts, judge_box(in_req)};
    end
    queued = verdicts.size();
  end

endmodule

FILE: tb/sv/testbench.sv
// Top of the box suppression testbench: clock, reset, stimulus, output stalls and verdict.

module testbench;
  import cabs_pkg::*;

  // Index with no register behind it; writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  // Worst case is roughly 1700 boxes, each scanning up to a full table, plus long gaps and stalls
  localparam int unsigned LIMIT_CYCLES = 1500000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_CONF_THR;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_req_t               in_req = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_req_t              out_req;

  int unsigned mismatches;
  int unsigned backlog;

  // Register values as last written, used to steer the random boxes
  int unsigned conf_now = 32'(CONF_THR_RST);
  int unsigned cls_now  = 32'(CLASS_CNT_RST);

  in_req_t     img [$];      // boxes sent so far in the current image
  bit          tight = 1'b0; // back-to-back stretch, no input gaps
  int unsigned stall_hold = 0;
  int unsigned cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  class_aware_box_suppression u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_req   (out_req)
  );

  suppression_checker u_judge (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_req     (in_req),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_req    (out_req),
    .mismatches (mismatches),
    .backlog    (backlog)
  );

  // Watchdog: a hang or a lost result ends the run here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver back-pressure. Bursts of short stalls, quiet stretches with no
  // stall at all, and now and then a long hold so a result waits in the
  // output register while the next request is being judged.
  always @(negedge clk) begin
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9: begin
          out_stall  <= 1'b0;
          stall_hold <= $urandom_range(0, 8);
        end
        10, 11, 12, 13, 14, 15, 16: begin
          out_stall  <= 1'b1;
          stall_hold <= $urandom_range(0, 3);
        end
        17, 18: begin
          out_stall  <= 1'b0;
          stall_hold <= $urandom_range(50, 200);
        end
        default: begin
          out_stall  <= 1'b1;
          stall_hold <= $urandom_range(15, 60);
        end
      endcase
    end
  end

  function automatic in_req_t box_req(bit f, int unsigned c, int unsigned s, int unsigned l,
                                      int unsigned t, int unsigned r, int unsigned b);
    in_req_t q;
    q.first_of_image = f;
    q.class_index    = c[7:0];
    q.score          = s[15:0];
    q.box_left       = l[15:0];
    q.box_top        = t[15:0];
    q.box_right      = r[15:0];
    q.box_bottom     = b[15:0];
    return q;
  endfunction

  function automatic logic [15:0] clamp16(int v);
    if (v < 0) return 16'd0;
    if (v > 65535) return 16'hFFFF;
    return v[15:0];
  endfunction

  // Mostly small boxes so that many fit in the image without touching
  function automatic int unsigned pick_span();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(1, 64);
    if (roll < 95) return $urandom_range(65, 4000);
    return $urandom_range(4001, 65535);
  endfunction

  // One box of an image. Most are well formed: a score that passes, a valid
  // class (a few classes favoured so overlaps meet the same class), and either
  // a fresh box or a shaken copy of one already sent so the IoU lands near the
  // limit. About one in ten is pure noise across every bit of every field but the first-of-image flag.
  function automatic in_req_t draw_box(bit first, int unsigned jitter_pct);
    in_req_t     q;
    in_req_t     src;
    int unsigned roll, w, h, cls_top;
    int          d, e;
    roll = $urandom_range(0, 99);
    cls_top = (cls_now == 0) ? 0 : cls_now - 1;
    q.first_of_image = first;
    q.score = 16'($urandom_range(conf_now, 65535));
    if ($urandom_range(0, 99) < 60)
      q.class_index = 8'($urandom_range(0, (cls_top < 3) ? cls_top : 3));
    else
      q.class_index = 8'($urandom_range(0, cls_top));
    if (roll < 10) begin
      q.class_index = 8'($urandom_range(0, 255));
      q.score       = 16'($urandom_range(0, 65535));
      q.box_left    = 16'($urandom_range(0, 65535));
      q.box_top     = 16'($urandom_range(0, 65535));
      q.box_right   = 16'($urandom_range(0, 65535));
      q.box_bottom  = 16'($urandom_range(0, 65535));
    end else if (roll < 10 + jitter_pct && img.size() != 0) begin
      src = img[$urandom_range(0, img.size() - 1)];
      if ($urandom_range(0, 4) != 0) q.class_index = src.class_index;
      d = (src.box_right > src.box_left) ? int'(src.box_right - src.box_left) / 4 + 1 : 2;
      e = (src.box_bottom > src.box_top) ? int'(src.box_bottom - src.box_top) / 4 + 1 : 2;
      q.box_left   = clamp16(int'(src.box_left) + int'($urandom_range(0, 2 * d)) - d);
      q.box_right  = clamp16(int'(src.box_right) + int'($urandom_range(0, 2 * d)) - d);
      q.box_top    = clamp16(int'(src.box_top) + int'($urandom_range(0, 2 * e)) - e);
      q.box_bottom = clamp16(int'(src.box_bottom) + int'($urandom_range(0, 2 * e)) - e);
    end else begin
      w = pick_span();
      h = pick_span();
      q.box_left   = 16'($urandom_range(0, 65535 - w));
      q.box_top    = 16'($urandom_range(0, 65535 - h));
      q.box_right  = 16'(32'(q.box_left) + w);
      q.box_bottom = 16'(32'(q.box_top) + h);
    end
    return q;
  endfunction

  // Present one request and hold it until the block takes it
  task automatic send_box(in_req_t q);
    @(negedge clk);
    in_req   <= q;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Gap after an accepted request: none in a tight stretch, else mostly short
  task automatic idle_gap();
    int unsigned roll, n;
    roll = $urandom_range(0, 99);
    if (tight || roll < 60) n = 0;
    else if (roll < 95) n = $urandom_range(1, 4);
    else n = $urandom_range(15, 60);
    if (n != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Stop sending and wait until every result has been taken
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (backlog != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_CONF_THR:  conf_now = 32'(val);
      REG_CLASS_CNT: cls_now  = 32'(val[7:0]);
      default: ;
    endcase
  endtask

  task automatic set_thresholds(logic [15:0] conf, logic [15:0] ovl, logic [15:0] cnt);
    settle();
    write_reg(REG_CONF_THR, conf);
    write_reg(REG_OVL_THR, ovl);
    write_reg(REG_CLASS_CNT, cnt);
  endtask

  // Images of random length. One in ten is long and mostly fresh boxes, so
  // the kept table fills and later survivors see the table-full status. Now
  // and then an image opens without the first-of-image flag and so carries
  // on with the previous table.
  task automatic run_images(int unsigned n_items);
    int unsigned sent, len, k;
    bit          long_img;
    in_req_t     q;
    sent = 0;
    while (sent < n_items) begin
      long_img = ($urandom_range(0, 9) == 0);
      len = long_img ? $urandom_range(66, 100) : $urandom_range(1, 24);
      img.delete();
      for (k = 0; k < len && sent < n_items; k++) begin
        if ($urandom_range(0, 59) == 0) tight = !tight;
        q = draw_box(k == 0 && $urandom_range(0, 19) != 0, long_img ? 10 : 45);
        send_box(q);
        idle_gap();
        img = {img, q};
        sent++;
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed requests under the reset thresholds (0.25 score, 0.45 IoU, 80 classes)
    send_box(box_req(1, 0, 65535, 0, 0, 160, 160));      idle_gap(); // kept
    send_box(box_req(0, 0, 65000, 0, 0, 160, 160));      idle_gap(); // identical: suppressed
    send_box(box_req(0, 1, 64000, 0, 0, 160, 160));      idle_gap(); // other class: kept
    send_box(box_req(0, 0, 63000, 8, 8, 168, 168));      idle_gap(); // IoU ~0.82: suppressed
    send_box(box_req(0, 0, 62000, 80, 0, 240, 160));     idle_gap(); // IoU 1/3: kept
    send_box(box_req(0, 2, 16383, 1000, 1000, 1001, 1001)); idle_gap(); // just under score
    send_box(box_req(0, 2, 16384, 1000, 1000, 1001, 1001)); idle_gap(); // score on threshold
    send_box(box_req(0, 79, 30000, 2000, 2000, 2100, 2100)); idle_gap(); // top valid class
    send_box(box_req(0, 80, 30000, 3000, 3000, 3100, 3100)); idle_gap(); // first bad class
    send_box(box_req(0, 255, 30000, 3000, 3000, 3100, 3100)); idle_gap();
    send_box(box_req(0, 3, 30000, 500, 500, 500, 600));  idle_gap(); // zero width
    send_box(box_req(0, 3, 30000, 500, 600, 700, 600));  idle_gap(); // zero height
    send_box(box_req(0, 3, 30000, 700, 600, 500, 500));  idle_gap(); // inverted: extents 0
    send_box(box_req(0, 255, 0, 9, 9, 1, 1));            idle_gap(); // low score wins
    send_box(box_req(0, 200, 40000, 9, 9, 1, 1));        idle_gap(); // bad class beats shape
    send_box(box_req(0, 4, 65535, 0, 0, 65535, 65535));  idle_gap(); // whole image
    send_box(box_req(0, 4, 65000, 65534, 65534, 65535, 65535)); idle_gap(); // tiny corner
    send_box(box_req(0, 4, 64000, 0, 0, 65535, 65535)); idle_gap(); // whole image again
    send_box(box_req(0, 255, 65535, 65535, 65535, 65535, 65535)); idle_gap(); // all ones
    send_box(box_req(1, 0, 65535, 0, 0, 160, 160));      idle_gap(); // cleared table: kept
    send_box(box_req(1, 0, 0, 0, 0, 0, 0));              idle_gap(); // all zeros

    run_images(300);

    // Loosest setting: every score passes, any overlap suppresses, classes 0 to 254 valid
    set_thresholds(16'd0, 16'd0, 16'd255);
    write_reg(REG_UNUSED, 16'h5A5A);
    run_images(250);

    // Strictest: only full score, only near-identical boxes suppress (IoU above 65535/65536), one class
    set_thresholds(16'hFFFF, 16'hFFFF, 16'd1);
    run_images(150);

    // Class count of zero, written with junk in the upper byte
    set_thresholds(16'd0, 16'hFFFF, 16'hFF00);
    run_images(100);

    set_thresholds(16'($urandom_range(0, 40000)), 16'd32768, 16'hAB05);
    run_images(250);

    repeat (3) begin
      set_thresholds(16'($urandom_range(0, 50000)), 16'($urandom_range(0, 65535)),
                     16'($urandom_range(1, 255)));
      run_images(220);
    end

    settle();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && backlog == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: class_aware_box_suppression.f
rtl/cabs_pkg.sv
rtl/cabs_ctrl.sv
rtl/cabs_dp.sv
rtl/class_aware_box_suppression.sv
tb/sv/suppression_checker.sv
tb/sv/testbench.sv
